FILE: src/tcbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbc_pkg
// shared types and constants for the chained tea block cipher
// ----------------------------------------------------------------------------
package tcbc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 3'd4;

    // direction codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // tea round constant; the inverse start sum is delta times the round count
    localparam logic [31:0] TEA_DELTA   = 32'h9e37_79b9;
    localparam logic [63:0] CHAIN_RESET = 64'hffff_ffff_ffff_ffff;

    // one queued block: blk[63:32] is tea v0, blk[31:0] is v1
    typedef struct packed {
        logic [63:0] blk;
        logic        first;
    } t_item;

    // configuration seen by the cipher engine
    typedef struct packed {
        logic [3:0][31:0] key;
        logic             decrypt;
    } t_cfg;

    // tea mixing function of one half round
    function automatic logic [31:0] tea_mix(input logic [31:0] v,
                                            input logic [31:0] s,
                                            input logic [31:0] ka,
                                            input logic [31:0] kb);
        tea_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

endpackage

FILE: src/tcbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbc_front
// input side: takes block transfers, tags the start of a message and holds
// them in a short queue for the cipher engine
// ----------------------------------------------------------------------------
module tcbc_front #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [63:0]          i_data,   // block_high, block_low
    input  logic                 i_start,  // start_of_message
    output logic                 o_valid,
    output tcbc_pkg::t_item      o_item,
    input  logic                 i_pop
);
    import tcbc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push;
    t_item           w_item;

    // tea takes the low word as v0
    assign w_item.blk   = {i_data[31:0], i_data[63:32]};
    assign w_item.first = i_start;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

FILE: src/tcbc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbc_engine
// back end: one tea round per cycle, chaining state and the output register
// ----------------------------------------------------------------------------
module tcbc_engine #(
    parameter int ROUNDS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcbc_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  tcbc_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [63:0]      o_blk
);
    import tcbc_pkg::*;

    localparam int          RW      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [RW-1:0] LAST  = RW'(ROUNDS - 1);
    localparam logic [31:0] SUM_INV = 32'(64'(TEA_DELTA) * 64'(ROUNDS));

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_round, n_round;
    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_cc, n_cc;
    logic [63:0]   r_cm, n_cm;

    logic [31:0]   r_a, r_b, r_sum;
    logic [63:0]   r_in, r_core_in, r_res, r_out;
    logic          r_first, r_dec;

    logic [63:0]   w_core_in;
    logic [31:0]   w_ea, w_eb, w_da, w_db, w_na, w_nb;
    logic [63:0]   w_core_out, w_res;
    logic          w_last, w_out_free, w_load;

    // chaining on the way in
    always_comb begin
        if (i_item.first) begin
            w_core_in = i_item.blk;
        end else if (i_cfg.decrypt == MODE_DECRYPT) begin
            w_core_in = i_item.blk ^ r_cm;
        end else begin
            w_core_in = i_item.blk ^ r_cc;
        end
    end

    // one full round, forward and inverse
    assign w_ea = r_a + tea_mix(r_b, r_sum, i_cfg.key[0], i_cfg.key[1]);
    assign w_eb = r_b + tea_mix(w_ea, r_sum, i_cfg.key[2], i_cfg.key[3]);
    assign w_db = r_b - tea_mix(r_a, r_sum, i_cfg.key[2], i_cfg.key[3]);
    assign w_da = r_a - tea_mix(w_db, r_sum, i_cfg.key[0], i_cfg.key[1]);
    assign w_na = (r_dec == MODE_DECRYPT) ? w_da : w_ea;
    assign w_nb = (r_dec == MODE_DECRYPT) ? w_db : w_eb;
    assign w_core_out = {w_na, w_nb};

    // chaining on the way out
    always_comb begin
        if (r_first) begin
            w_res = w_core_out;
        end else if (r_dec == MODE_DECRYPT) begin
            w_res = w_core_out ^ r_cc;
        end else begin
            w_res = w_core_out ^ r_cm;
        end
    end

    assign w_last     = (r_state == ST_RUN) && (r_round == LAST);
    assign w_out_free = !r_ovalid || i_ready;
    assign w_load     = w_out_free && (w_last || (r_state == ST_HOLD));
    assign o_pop      = (r_state == ST_IDLE) && i_valid;
    assign o_valid    = r_ovalid;
    assign o_blk      = r_out;

    always_comb begin
        n_state  = r_state;
        n_round  = r_round;
        n_ovalid = r_ovalid && !i_ready;
        n_cc     = r_cc;
        n_cm     = r_cm;
        if (w_load) begin
            n_ovalid = 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                    n_round = '0;
                end
            end
            ST_RUN: begin
                n_round = r_round + 1'b1;
                if (w_last) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                    if (r_dec == MODE_DECRYPT) begin
                        n_cm = w_core_out;
                        n_cc = r_in;
                    end else begin
                        n_cm = r_core_in;
                        n_cc = w_res;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_round  <= '0;
            r_ovalid <= 1'b0;
            r_cc     <= CHAIN_RESET;
            r_cm     <= CHAIN_RESET;
        end else begin
            r_state  <= n_state;
            r_round  <= n_round;
            r_ovalid <= n_ovalid;
            r_cc     <= n_cc;
            r_cm     <= n_cm;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_in      <= i_item.blk;
            r_core_in <= w_core_in;
            r_a       <= w_core_in[63:32];
            r_b       <= w_core_in[31:0];
            r_first   <= i_item.first;
            r_dec     <= i_cfg.decrypt;
            r_sum     <= (i_cfg.decrypt == MODE_DECRYPT) ? SUM_INV : TEA_DELTA;
        end else if (r_state == ST_RUN) begin
            r_a   <= w_na;
            r_b   <= w_nb;
            r_sum <= (r_dec == MODE_DECRYPT) ? r_sum - TEA_DELTA : r_sum + TEA_DELTA;
        end
        if (w_last) begin
            r_res <= w_res;
        end
        if (w_load) begin
            r_out <= w_last ? w_res : r_res;
        end
    end

`ifndef ASSERT_OFF
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state == ST_RUN && r_round == '0))
        else $error("engine did not start rounds after taking a block");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_ovalid)
        else $error("result held back while output register is empty");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_pop)
        else $error("queue popped while engine busy");
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_round <= LAST))
        else $error("round counter ran past the last round");
`endif

endmodule

FILE: src/tea_chained_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_chained_block_cipher
// tea encryption and decryption of 64-bit blocks with cross-chaining
// ----------------------------------------------------------------------------
//  channel | direction | handshake                      | payload
//  s       | in        | i_s_tvalid / o_s_tready        | i_s_tdata, i_s_tuser
//  m       | out       | o_m_tvalid / i_m_tready        | o_m_tdata
//  cfg     | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  each block is loaded in the engine's idle state, then gets one tea round per
//  cycle in the run state and waits in the hold state while the output register
//  is full; the single round unit and block-to-block chain allow one block at a time
//  reset is synchronous active low and clears the chain to all ones, no sweep
//  the input queue keeps taking transfers while the engine works, and a result
//  waiting in the output register does not block the next block's rounds
// ----------------------------------------------------------------------------
module tea_chained_block_cipher #(
    parameter int ROUNDS      = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // block input
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [63:0]                    i_s_tdata,   // block_high, block_low
    input  logic                           i_s_tuser,   // start_of_message
    // block output
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [63:0]                    o_m_tdata,   // out_high, out_low
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import tcbc_pkg::*;

    t_cfg        r_cfg;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_pop;
    logic [63:0] w_blk;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_WORD0:    r_cfg.key[0]  <= i_cfg_data;
                CFG_KEY_WORD1:    r_cfg.key[1]  <= i_cfg_data;
                CFG_KEY_WORD2:    r_cfg.key[2]  <= i_cfg_data;
                CFG_KEY_WORD3:    r_cfg.key[3]  <= i_cfg_data;
                CFG_DECRYPT_MODE: r_cfg.decrypt <= i_cfg_data[0];
                default:          r_cfg         <= r_cfg;
            endcase
        end
    end

    // front end: transfer capture and queue
    tcbc_front #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_start (i_s_tuser),
        .o_valid (w_item_valid),
        .o_item  (w_item),
        .i_pop   (w_pop)
    );

    // back end: rounds, chaining, output register
    tcbc_engine #(
        .ROUNDS  (ROUNDS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_item_valid),
        .i_item  (w_item),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_blk   (w_blk)
    );

    // out_high in the high half of tdata
    assign o_m_tdata = {w_blk[31:0], w_blk[63:32]};

endmodule
